### hw/rtl/note_timebase_requantiser_assert.svh
// Assertion macros shared by the checker of note_timebase_requantiser.
// Included by bare file name; holds macro definitions only.
`ifndef NOTE_TIMEBASE_REQUANTISER_ASSERT_SVH
`define NOTE_TIMEBASE_REQUANTISER_ASSERT_SVH

// Clocked assertion, off while reset is held low.
`define NTR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ntr assertion failed");

// Clocked assertion that also holds across reset.
`define NTR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ntr assertion failed");

`endif

### hw/rtl/ntr_pkg.sv
// Shared types, widths and register codes of the note timebase requantiser.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package ntr_pkg;

    localparam int TICK_BITS_DEF = 32;
    localparam int IN_TICK_W     = 32;
    localparam int PPQ_W         = 14;
    localparam int OUT_W         = 48;
    localparam int PITCH_W       = 7;
    localparam int VEL_W         = 7;
    localparam int CHAN_W        = 5;

    localparam int IN_DATA_W     = 88;
    localparam int OUT_DATA_W    = 120;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [15:0] SOURCE_PPQ_RST = 16'd480;
    localparam logic [15:0] DEST_PPQ_RST   = 16'd480;

    // register select, taken from the word address bit
    localparam logic REG_SOURCE_PPQ = 1'b0;
    localparam logic REG_DEST_PPQ   = 1'b1;

    // tick bits actually taken from the 32-bit input fields
    function automatic int used_bits(input int tick_bits);
        int ub;
        ub = (tick_bits < IN_TICK_W) ? tick_bits : IN_TICK_W;
        return ub;
    endfunction

    // numerator width: (start+len) * dest * 2 + source
    function automatic int div_bits(input int tick_bits);
        int nw;
        nw = used_bits(tick_bits) + 1 + PPQ_W + 2;
        return nw;
    endfunction

    typedef struct packed {
        logic load;     // capture input beat
        logic mul;      // form numerator
        logic sel_end;  // numerator from end tick instead of start tick
        logic step;     // one restoring division step
        logic grp;      // update group start from quotient
        logic qend;     // form clamped end from quotient
        logic emit;     // load output register
    } t_cmd;

endpackage

`default_nettype wire

### hw/rtl/ntr_ctrl.sv
// Sequencer of the requantiser: handshakes and command stream to ntr_datapath.
// Depends on ntr_pkg.
`default_nettype none

module ntr_ctrl #(
    parameter int TICK_BITS = ntr_pkg::TICK_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    output ntr_pkg::t_cmd  o_cmd
);

    localparam int NW = ntr_pkg::div_bits(TICK_BITS);
    localparam int CW = $clog2(NW);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_S, S_DIV_S, S_GRP, S_MUL_E, S_DIV_E, S_QEND, S_EMIT
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [CW-1:0]   r_cnt;
    logic            r_valid;
    logic            w_last_step;
    logic            w_out_free;

    assign w_last_step = (r_cnt == CW'(NW - 1));
    assign w_out_free  = !r_valid || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_S;
                end
            end
            S_MUL_S: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV_S;
            end
            S_DIV_S: begin
                o_cmd.step = 1'b1;
                if (w_last_step) n_state = S_GRP;
            end
            S_GRP: begin
                o_cmd.grp = 1'b1;
                n_state   = S_MUL_E;
            end
            S_MUL_E: begin
                o_cmd.mul     = 1'b1;
                o_cmd.sel_end = 1'b1;
                n_state       = S_DIV_E;
            end
            S_DIV_E: begin
                o_cmd.step = 1'b1;
                if (w_last_step) n_state = S_QEND;
            end
            S_QEND: begin
                o_cmd.qend = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.mul) begin
                r_cnt <= '0;
            end else if (o_cmd.step) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (o_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ntr_datapath.sv
// Datapath of the requantiser: multiplier, serial restoring divider, group state.
// Depends on ntr_pkg; driven by ntr_ctrl commands.
`default_nettype none

module ntr_datapath #(
    parameter int TICK_BITS = ntr_pkg::TICK_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ntr_pkg::t_cmd                  i_cmd,
    input  logic [ntr_pkg::PPQ_W-1:0]      i_source_ppq,
    input  logic [ntr_pkg::PPQ_W-1:0]      i_dest_ppq,
    input  logic [ntr_pkg::IN_TICK_W-1:0]  i_start_tick,
    input  logic [ntr_pkg::IN_TICK_W-1:0]  i_length_ticks,
    input  logic [ntr_pkg::PITCH_W-1:0]    i_pitch,
    input  logic [ntr_pkg::VEL_W-1:0]      i_velocity,
    input  logic [ntr_pkg::CHAN_W-1:0]     i_channel,
    input  logic                           i_first_of_clip,
    output logic [ntr_pkg::OUT_W-1:0]      o_out_start,
    output logic [ntr_pkg::OUT_W-1:0]      o_out_length,
    output logic [ntr_pkg::PITCH_W-1:0]    o_out_pitch,
    output logic [ntr_pkg::VEL_W-1:0]      o_out_velocity,
    output logic [ntr_pkg::CHAN_W-1:0]     o_out_channel
);

    localparam int UB = ntr_pkg::used_bits(TICK_BITS);
    localparam int SB = UB + 1;
    localparam int PW = SB + ntr_pkg::PPQ_W;
    localparam int NW = ntr_pkg::div_bits(TICK_BITS);
    localparam int DW = ntr_pkg::PPQ_W + 1;
    localparam int OW = ntr_pkg::OUT_W;

    logic [SB-1:0]  r_tick_s;
    logic [SB-1:0]  r_tick_e;
    logic [UB-1:0]  r_last;
    logic           r_first;
    logic           r_new;
    logic [NW-1:0]  r_num;
    logic [DW-1:0]  r_rem;
    logic [OW-1:0]  r_gqs;
    logic [OW-1:0]  r_run_end;
    logic [OW-1:0]  r_qend;
    logic [ntr_pkg::PITCH_W-1:0] r_pitch;
    logic [ntr_pkg::VEL_W-1:0]   r_velocity;
    logic [ntr_pkg::CHAN_W-1:0]  r_channel;
    logic [OW-1:0]  r_o_start;
    logic [OW-1:0]  r_o_length;
    logic [ntr_pkg::PITCH_W-1:0] r_o_pitch;
    logic [ntr_pkg::VEL_W-1:0]   r_o_velocity;
    logic [ntr_pkg::CHAN_W-1:0]  r_o_channel;

    logic [UB-1:0]  w_start_u;
    logic [UB-1:0]  w_len_u;
    logic [ntr_pkg::PPQ_W-1:0] w_src;
    logic [DW-1:0]  w_div;
    logic [SB-1:0]  w_tick;
    logic [PW-1:0]  w_prod;
    logic [NW-1:0]  n_num_init;
    logic [DW:0]    w_rem_sh;
    logic [DW:0]    w_rem_sub;
    logic           w_ge;
    logic [DW-1:0]  n_rem;
    logic [OW-1:0]  w_q;
    logic [OW-1:0]  w_prev;
    logic [OW-1:0]  n_qs;
    logic [OW-1:0]  w_gqs_inc;
    logic [OW-1:0]  n_qend;
    logic [OW-1:0]  n_run_end;

    assign w_start_u = i_start_tick[UB-1:0];
    assign w_len_u   = i_length_ticks[UB-1:0];

    // zero source resolution counts as one
    assign w_src = (i_source_ppq == '0) ? ntr_pkg::PPQ_W'(1) : i_source_ppq;
    assign w_div = {w_src, 1'b0};

    // numerator 2*tick*dest + src rounds half up after division by 2*src
    assign w_tick     = i_cmd.sel_end ? r_tick_e : r_tick_s;
    assign w_prod     = w_tick * i_dest_ppq;
    assign n_num_init = {1'b0, w_prod, 1'b0} + NW'(w_src);

    // restoring step: remainder stays below the divisor
    assign w_rem_sh  = {r_rem, r_num[NW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, w_div});
    assign w_rem_sub = w_rem_sh - {1'b0, w_div};
    assign n_rem     = w_ge ? w_rem_sub[DW-1:0] : w_rem_sh[DW-1:0];

    // quotient never reaches 2^47, so the output saturation never applies
    assign w_q       = OW'(r_num);
    assign w_prev    = r_first ? '0 : r_run_end;
    assign n_qs      = (w_q < w_prev) ? w_prev : w_q;
    assign w_gqs_inc = r_gqs + OW'(1);
    assign n_qend    = (w_q < w_gqs_inc) ? w_gqs_inc : w_q;
    assign n_run_end = (r_qend > r_run_end) ? r_qend : r_run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_gqs     <= '0;
            r_run_end <= '0;
        end else begin
            if (i_cmd.load) begin
                r_last <= w_start_u;
            end
            if (i_cmd.grp && r_new) begin
                r_gqs     <= n_qs;
                r_run_end <= n_qs + OW'(1);
            end
            if (i_cmd.emit) begin
                r_run_end <= n_run_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tick_s   <= SB'(w_start_u);
            r_tick_e   <= SB'(w_start_u) + SB'(w_len_u);
            r_first    <= i_first_of_clip;
            r_new      <= i_first_of_clip || (w_start_u != r_last);
            r_pitch    <= i_pitch;
            r_velocity <= i_velocity;
            r_channel  <= i_channel;
        end
        if (i_cmd.mul) begin
            r_num <= n_num_init;
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_num <= {r_num[NW-2:0], w_ge};
            r_rem <= n_rem;
        end
        if (i_cmd.qend) begin
            r_qend <= n_qend;
        end
        if (i_cmd.emit) begin
            r_o_start    <= r_gqs;
            r_o_length   <= r_qend - r_gqs;
            r_o_pitch    <= r_pitch;
            r_o_velocity <= r_velocity;
            r_o_channel  <= r_channel;
        end
    end

    assign o_out_start    = r_o_start;
    assign o_out_length   = r_o_length;
    assign o_out_pitch    = r_o_pitch;
    assign o_out_velocity = r_o_velocity;
    assign o_out_channel  = r_o_channel;

endmodule

`default_nettype wire

### hw/rtl/note_timebase_requantiser.sv
// One beat is processed at a time: o_s_tready is high only while idle.
// NW = min(TICK_BITS,32)+17 is the width of each division's numerator.
// The pace is set by two serial divisions of NW quotient bits on one divider.
// The output register lets the next beat in while a result waits.
// Reset (synchronous, i_rst_n low) clears group history and output valid and
// sets both resolutions to 480 ticks per quarter.
`default_nettype none

module note_timebase_requantiser #(
    parameter int TICK_BITS = ntr_pkg::TICK_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // start_tick[31:0], length_ticks[63:32], pitch[70:64], velocity[77:71],
    // channel[82:78], zero pad[87:83]
    input  logic [ntr_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // first_of_clip[0]
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // out_start[47:0], out_length[95:48], out_pitch[102:96],
    // out_velocity[109:103], out_channel[114:110], zero pad[119:115]
    output logic [ntr_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ntr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ntr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ntr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int PW = ntr_pkg::PPQ_W;

    logic [PW-1:0]               r_source_ppq;
    logic [PW-1:0]               r_dest_ppq;
    ntr_pkg::t_cmd               w_cmd;
    logic [ntr_pkg::OUT_W-1:0]   w_out_start;
    logic [ntr_pkg::OUT_W-1:0]   w_out_length;
    logic [ntr_pkg::PITCH_W-1:0] w_out_pitch;
    logic [ntr_pkg::VEL_W-1:0]   w_out_velocity;
    logic [ntr_pkg::CHAN_W-1:0]  w_out_channel;
    logic                        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_ppq <= ntr_pkg::SOURCE_PPQ_RST[PW-1:0];
            r_dest_ppq   <= ntr_pkg::DEST_PPQ_RST[PW-1:0];
        end else if (w_wr) begin
            case (paddr[2])
                ntr_pkg::REG_SOURCE_PPQ: r_source_ppq <= pwdata[PW-1:0];
                ntr_pkg::REG_DEST_PPQ:   r_dest_ppq   <= pwdata[PW-1:0];
                default:                 r_dest_ppq   <= r_dest_ppq;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ntr_pkg::REG_SOURCE_PPQ: prdata = ntr_pkg::APB_DATA_W'(r_source_ppq);
            ntr_pkg::REG_DEST_PPQ:   prdata = ntr_pkg::APB_DATA_W'(r_dest_ppq);
            default:                 prdata = '0;
        endcase
    end

    ntr_ctrl #(
        .TICK_BITS (TICK_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    ntr_datapath #(
        .TICK_BITS (TICK_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_source_ppq    (r_source_ppq),
        .i_dest_ppq      (r_dest_ppq),
        .i_start_tick    (i_s_tdata[31:0]),
        .i_length_ticks  (i_s_tdata[63:32]),
        .i_pitch         (i_s_tdata[70:64]),
        .i_velocity      (i_s_tdata[77:71]),
        .i_channel       (i_s_tdata[82:78]),
        .i_first_of_clip (i_s_tuser),
        .o_out_start     (w_out_start),
        .o_out_length    (w_out_length),
        .o_out_pitch     (w_out_pitch),
        .o_out_velocity  (w_out_velocity),
        .o_out_channel   (w_out_channel)
    );

    assign o_m_tdata = {5'b0, w_out_channel, w_out_velocity, w_out_pitch,
                        w_out_length, w_out_start};

endmodule

`default_nettype wire

### hw/rtl/ntr_checker.sv
// Port-level checker for note_timebase_requantiser, attached by bind.
// Depends on ntr_pkg and note_timebase_requantiser_assert.svh.
`default_nettype none

`include "note_timebase_requantiser_assert.svh"

module ntr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           i_s_tready,
    input logic                           i_m_tvalid,
    input logic                           i_m_tready,
    input logic [ntr_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input logic                           i_pready
);

    `NTR_ASSERT(a_out_hold, i_clk, i_rst_n, (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
    `NTR_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_s_tvalid && i_s_tready) |=> !i_s_tready)
    `NTR_ASSERT(a_len_nonzero, i_clk, i_rst_n, i_m_tvalid |-> (i_m_tdata[95:48] != 48'd0))
    `NTR_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_m_tvalid)
    `NTR_ASSERT(a_pready_high, i_clk, i_rst_n, i_pready)

endmodule

bind note_timebase_requantiser ntr_checker u_ntr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_pready   (pready)
);

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for note_timebase_requantiser: random and directed note streams,
// per-beat prediction of the requantised start and length, APB register writes between phases.
// Depends on ntr_pkg and the RTL of note_timebase_requantiser only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] OUT_SAT     = 48'hFFFF_FFFF_FFFF;
    localparam int          HOLD_CYCLES = 1500;
    localparam int          SETTLE      = 120;
    localparam int          NUM_PHASES  = 7;
    localparam int          PHASE_NOTES = 146;

    typedef struct packed {
        logic [4:0]  pad;
        logic [4:0]  chan;
        logic [6:0]  vel;
        logic [6:0]  pitch;
        logic [31:0] len;
        logic [31:0] start;
    } t_note_in;

    typedef struct packed {
        logic [4:0]  pad;
        logic [4:0]  chan;
        logic [6:0]  vel;
        logic [6:0]  pitch;
        logic [47:0] len;
        logic [47:0] start;
    } t_note_out;

    typedef struct {
        t_note_in note;
        logic     first;
        int       gap;
    } t_pending_note;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [ntr_pkg::IN_DATA_W-1:0]    i_s_tdata = '0;
    logic                             i_s_tuser = 1'b0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [ntr_pkg::OUT_DATA_W-1:0]   o_m_tdata;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [ntr_pkg::APB_ADDR_W-1:0]   paddr = '0;
    logic [ntr_pkg::APB_DATA_W-1:0]   pwdata = '0;
    logic [ntr_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    note_timebase_requantiser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // timebase and group history as the block should hold them
    logic [13:0] src_ppq = 14'd480;
    logic [13:0] dst_ppq = 14'd480;
    logic [31:0] grp_orig_start = '0;
    logic [47:0] prev_grp_end = '0;
    logic [47:0] grp_start = '0;
    logic [47:0] run_grp_end = '0;

    t_pending_note pending_notes[$];
    t_note_out     expected_notes[$];
    t_note_in      tx_note;
    int            tx_wait = 0;
    int            rx_wait = 0;
    int            hold_cnt = 0;
    int            last_hold_mark = -1;
    int            notes_in = 0;
    int            notes_out = 0;
    int            notes_queued = 0;
    int            mismatches = 0;
    logic [31:0]   gen_start = '0;

    // round(tick * dst / src), halves away from zero
    function automatic logic [47:0] rescale_tick(input logic [32:0] tick);
        logic [63:0] div;
        logic [63:0] num;
        logic [63:0] q;
        div = (src_ppq == '0) ? 64'd1 : 64'(src_ppq);
        num = 64'(tick) * 64'(dst_ppq) * 64'd2 + div;
        q = num / (div * 64'd2);
        return (q > 64'(OUT_SAT)) ? OUT_SAT : q[47:0];
    endfunction

    function automatic t_note_out requantise(input t_note_in n, input logic first);
        t_note_out   r;
        logic [47:0] qs;
        logic [47:0] qend;
        if (first || n.start != grp_orig_start) begin
            prev_grp_end = first ? '0 : run_grp_end;
            qs = rescale_tick({1'b0, n.start});
            if (qs < prev_grp_end)
                qs = prev_grp_end;
            if (qs > OUT_SAT - 48'd1)
                qs = OUT_SAT - 48'd1;
            grp_start = qs;
            run_grp_end = qs + 48'd1;
        end
        grp_orig_start = n.start;
        qend = rescale_tick({1'b0, n.start} + {1'b0, n.len});
        if (qend < grp_start + 48'd1)
            qend = grp_start + 48'd1;
        if (qend > run_grp_end)
            run_grp_end = qend;
        r.pad = '0;
        r.chan = n.chan;
        r.vel = n.vel;
        r.pitch = n.pitch;
        r.len = qend - grp_start;
        r.start = grp_start;
        return r;
    endfunction

    // alternate stretches without idling and stretches with random gaps
    function automatic int draw_gap(input int n);
        return ((n / 48) % 3 == 0) ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic check_field(input string what, input logic [47:0] want, input logic [47:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    // sender: present queued notes, each after its own idle gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            tx_wait <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_notes = {expected_notes, requantise(tx_note, i_s_tuser)};
                notes_in <= notes_in + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_notes.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else if (tx_wait < pending_notes[0].gap) begin
                    tx_wait <= tx_wait + 1;
                    i_s_tvalid <= 1'b0;
                end else begin
                    pending_notes_pop();
                    tx_wait <= 0;
                    i_s_tvalid <= 1'b1;
                end
            end
        end
    end

    task automatic pending_notes_pop();
        t_pending_note p;
        p = pending_notes.pop_front();
        tx_note <= p.note;
        i_s_tdata <= p.note;
        i_s_tuser <= p.first;
    endtask

    // long output stalls so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if ((notes_in == 150 || notes_in == 600) && last_hold_mark != notes_in) begin
            hold_cnt <= HOLD_CYCLES;
            last_hold_mark <= notes_in;
        end
    end

    // receiver: check each result beat against the oldest expected note
    always @(posedge i_clk) begin : rx_side
        int nxt;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            nxt = (rx_wait > 0) ? rx_wait - 1 : 0;
            if (o_m_tvalid && i_m_tready) begin
                t_note_out got;
                t_note_out want;
                got = o_m_tdata;
                notes_out <= notes_out + 1;
                if (expected_notes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result expected none actual %0h", $time, got);
                end else begin
                    want = expected_notes.pop_front();
                    check_field("start", want.start, got.start);
                    check_field("length", want.len, got.len);
                    check_field("pitch", 48'(want.pitch), 48'(got.pitch));
                    check_field("velocity", 48'(want.vel), 48'(got.vel));
                    check_field("channel", 48'(want.chan), 48'(got.chan));
                end
                nxt = draw_gap(notes_out + 17);
            end
            rx_wait <= nxt;
            i_m_tready <= (nxt == 0) && (hold_cnt == 0);
        end
    end

    task automatic add_note(input logic [31:0] start, input logic [31:0] len,
                            input logic [6:0] pitch, input logic [6:0] vel,
                            input logic [4:0] chan, input logic first);
        t_pending_note p;
        p.note = '{pad: '0, chan: chan, vel: vel, pitch: pitch, len: len, start: start};
        p.first = first;
        p.gap = draw_gap(notes_queued);
        pending_notes = {pending_notes, p};
        notes_queued++;
    endtask

    // mostly ordered clips with chords; some restarts, backward starts and wild jumps
    task automatic add_random_notes(input int count);
        int          r;
        int          k;
        logic        first;
        logic [31:0] len;
        logic [4:0]  chan;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            first = ($urandom_range(0, 19) == 0);
            if (r < 40) begin
                // same start: another chord member
            end else if (r < 75) begin
                gen_start = gen_start + $urandom_range(1, 2000);
            end else if (r < 82) begin
                gen_start = gen_start + $urandom;
            end else if (r < 88) begin
                gen_start = $urandom_range(0, 5000);
                first = 1'b1;
            end else if (r < 94) begin
                gen_start = gen_start - $urandom_range(1, 3000);
            end else begin
                gen_start = $urandom;
            end
            k = $urandom_range(0, 9);
            if (k == 0)
                len = '0;
            else if (k < 7)
                len = $urandom_range(1, 3000);
            else if (k < 9)
                len = $urandom_range(1, 100000);
            else
                len = $urandom;
            chan = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 16));
            add_note(gen_start, len, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                     chan, first);
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_notes.size() != 0 || i_s_tvalid || expected_notes.size() != 0);
    endtask

    // write one resolution register, then read it back
    task automatic write_ppq(input logic sel, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (sel == ntr_pkg::REG_SOURCE_PPQ)
            src_ppq = value[13:0];
        else
            dst_ppq = value[13:0];
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {18'd0, value[13:0]}) begin
            mismatches++;
            $display("%0t: register %0d readback expected %0h actual %0h",
                     $time, sel, {18'd0, value[13:0]}, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        logic [31:0] src_set[NUM_PHASES];
        logic [31:0] dst_set[NUM_PHASES];
        src_set = '{32'd1, 32'd9600, 32'd2, 32'd0, 32'hFFFF_C007, 32'd480, 32'd480};
        dst_set = '{32'd9600, 32'd24, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd24, 32'd480};
        src_set[5] = $urandom_range(1, 9600);
        dst_set[5] = $urandom_range(24, 9600);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed notes at the reset timebase
        add_note(32'd0, 32'd0, 7'd60, 7'd100, 5'd1, 1'b0);     // joins the empty reset group
        add_note(32'd0, 32'd480, 7'd64, 7'd90, 5'd1, 1'b0);
        add_note(32'd0, 32'hFFFF_FFFF, 7'd67, 7'd80, 5'd16, 1'b0);
        add_note(32'd100, 32'd50, 7'd127, 7'd127, 5'd31, 1'b0); // pushed past a long group
        add_note(32'd100, 32'd10, 7'd0, 7'd0, 5'd0, 1'b1);      // restart with the same start
        add_note(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h55, 7'h2A, 5'h15, 1'b0);
        add_note(32'hFFFF_FFFF, 32'd0, 7'h2A, 7'h55, 5'h0A, 1'b1);
        add_note(32'hFFFF_FFFF, 32'd1, 7'd1, 7'd2, 5'd3, 1'b0);
        add_note(32'd0, 32'd7, 7'd10, 7'd20, 5'd4, 1'b1);
        add_note(32'd5, 32'd3, 7'd11, 7'd21, 5'd5, 1'b0);
        add_note(32'd5, 32'd900, 7'd12, 7'd22, 5'd6, 1'b0);
        add_note(32'd5, 32'd1, 7'd13, 7'd23, 5'd7, 1'b0);
        add_note(32'd1000, 32'd0, 7'd14, 7'd24, 5'd8, 1'b0);
        add_note(32'd960, 32'd10, 7'd15, 7'd25, 5'd9, 1'b0);   // backward start, no restart
        add_note(32'hAAAA_AAAA, 32'h5555_5555, 7'd16, 7'd26, 5'd10, 1'b0);
        add_note(32'h5555_5555, 32'hAAAA_AAAA, 7'd17, 7'd27, 5'd11, 1'b1);
        add_note(32'h5555_5555, 32'd0, 7'd18, 7'd28, 5'd12, 1'b0);
        add_note(32'h8000_0000, 32'h8000_0000, 7'd19, 7'd29, 5'd13, 1'b0);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_ppq(ntr_pkg::REG_SOURCE_PPQ, src_set[ph]);
            write_ppq(ntr_pkg::REG_DEST_PPQ, dst_set[ph]);
            gen_start = $urandom_range(0, 1000);
            add_note(gen_start, $urandom_range(0, 2000), 7'd60, 7'd64, 5'd1, 1'b1);
            add_random_notes(PHASE_NOTES);
            wait_idle();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (expected_notes.size() != 0) begin
            mismatches++;
            $display("%0t: results missing expected %0d actual 0",
                     $time, expected_notes.size());
        end
        $display("Sent %0d notes and checked %0d results over %0d timebases plus the reset one,",
                 notes_in, notes_out, NUM_PHASES);
        $display("covering chords, clip restarts, backward starts, wrapped ends and output stalls.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_notes.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
